FILE: hw/rtl/rpdt_pkg.sv
package rpdt_pkg;

  localparam int ROUTES = 16;
  localparam int SEGS = 64;
  localparam int POINTS = 256;
  localparam int RT_W = 4;
  localparam int SEG_W = 7;
  localparam int SI_W = 6;
  localparam int PT_W = 8;
  localparam int POS_W = 22;
  localparam int SEG_ENTRIES = ROUTES * SEGS;
  localparam int SA_W = RT_W + SI_W;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_SEG   = 2'd0,
    MODE_POINT = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FIRST   = 2'd1,
    ST_SECOND  = 2'd2,
    ST_ROUTES  = 2'd3
  } status_t;

  typedef struct packed {
    mode_t             mode;
    logic [RT_W-1:0]   route;
    logic [SEG_W-1:0]  segment;
    logic [15:0]       seg_length;
    logic [15:0]       point_offset;
    logic [PT_W-1:0]   point_id;
    logic [PT_W-1:0]   other_point_id;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_PT_RD,
    BK_PT_WAIT,
    BK_CHECK,
    BK_ACC_RD,
    BK_ACC,
    BK_NEXT_PT,
    BK_DONE,
    BK_OUT
  } bk_state_t;

endpackage

FILE: hw/rtl/rpdt_front.sv
module rpdt_front
  import rpdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmd_t       in_cmd,
  output logic       q_valid,
  input  logic       q_ready,
  output cmd_t       q_cmd
);

  // two-entry queue; mode three items are dropped here
  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready && (in_cmd.mode != MODE_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push || pop) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("bad count");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r) else $error("pointer slip");
`endif

endmodule

FILE: hw/rtl/rpdt_back.sv
module rpdt_back
  import rpdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  cmd_t              q_cmd,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [1:0]        res_status,
  output logic [POS_W-1:0]  res_first,
  output logic [POS_W-1:0]  res_second,
  output logic [POS_W-1:0]  res_dist
);

  bk_state_t state_r, state_nxt;

  // segment length store, one write and one registered read port
  logic [15:0]        seg_mem [SEG_ENTRIES];
  logic [15:0]        seg_rd_r;
  logic               seg_we;
  logic [SA_W-1:0]    seg_wa, seg_ra;
  logic [15:0]        seg_wd;

  // point store, reset undefined
  logic [RT_W+SEG_W+16-1:0] pt_mem [POINTS];
  logic [RT_W+SEG_W+16-1:0] pt_rd_r;
  logic                     pt_we;
  logic [PT_W-1:0]          pt_ra;

  logic [ROUTES-1:0]  rpres_r;
  logic [SEG_W-1:0]   rtop_r [ROUTES];
  logic [POINTS-1:0]  ppres_r;

  logic [SA_W-1:0]    clr_r, clr_nxt;
  cmd_t               cmd_r;
  logic               which_r, which_nxt;
  logic [SI_W-1:0]    k_r, k_nxt;
  logic [POS_W-1:0]   acc_r, acc_nxt;
  logic [POS_W-1:0]   pos_a_r, pos_a_nxt, pos_b_r, pos_b_nxt;
  logic               va_r, va_nxt, vb_r, vb_nxt;
  logic [RT_W-1:0]    ra_r, ra_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [POS_W-1:0]   dist_r, dist_nxt;

  logic [RT_W-1:0]    p_rt;
  logic [SEG_W-1:0]   p_seg;
  logic [15:0]        p_off;
  logic               seg_ok;
  logic [POS_W:0]     sum;
  logic [POS_W:0]     sum_off;
  logic               take;

  assign p_rt  = pt_rd_r[RT_W+SEG_W+16-1 -: RT_W];
  assign p_seg = pt_rd_r[SEG_W+16-1 -: SEG_W];
  assign p_off = pt_rd_r[15:0];
  assign seg_ok = (q_cmd.segment != '0) && (q_cmd.segment <= SEG_W'(SEGS));
  assign sum = {1'b0, acc_r} + (POS_W+1)'(seg_rd_r[15] ? 16'd0 : seg_rd_r);
  assign sum_off = {1'b0, acc_r} + (POS_W+1)'(p_off);
  assign take = q_valid && (state_r == BK_IDLE);
  assign q_ready = take;
  assign out_tvalid = (state_r == BK_OUT);
  assign res_status = st_r;
  assign res_first = pos_a_r;
  assign res_second = pos_b_r;
  assign res_dist = dist_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    which_nxt = which_r;
    k_nxt = k_r;
    acc_nxt = acc_r;
    pos_a_nxt = pos_a_r;
    pos_b_nxt = pos_b_r;
    va_nxt = va_r;
    vb_nxt = vb_r;
    ra_nxt = ra_r;
    st_nxt = st_r;
    dist_nxt = dist_r;
    seg_we = 1'b0;
    seg_wa = {q_cmd.route, SI_W'(q_cmd.segment - SEG_W'(1))};
    seg_wd = q_cmd.seg_length;
    seg_ra = {p_rt, k_r};
    pt_we = 1'b0;
    pt_ra = which_r ? cmd_r.other_point_id : cmd_r.point_id;
    case (state_r)
      BK_CLEAR: begin
        seg_we = 1'b1;
        seg_wa = clr_r;
        seg_wd = '0;
        clr_nxt = clr_r + SA_W'(1);
        if (clr_r == SA_W'(SEG_ENTRIES - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.mode)
            MODE_SEG: seg_we = seg_ok;
            MODE_POINT: pt_we = 1'b1;
            MODE_QUERY: begin
              which_nxt = 1'b0;
              state_nxt = BK_PT_RD;
            end
            default: ;
          endcase
        end
      end
      BK_PT_RD: state_nxt = BK_PT_WAIT;
      BK_PT_WAIT: begin
        // read the point's own segment length
        seg_ra = {p_rt, SI_W'(p_seg - SEG_W'(1))};
        state_nxt = BK_CHECK;
      end
      BK_CHECK: begin
        k_nxt = '0;
        acc_nxt = '0;
        if (!ppres_r[pt_ra] || !rpres_r[p_rt] || p_seg == '0 ||
            p_seg > rtop_r[p_rt] || p_seg > SEG_W'(SEGS) ||
            seg_rd_r == '0 || seg_rd_r[15]) begin
          if (which_r) begin
            vb_nxt = 1'b0;
            pos_b_nxt = '0;
          end else begin
            va_nxt = 1'b0;
            pos_a_nxt = '0;
          end
          state_nxt = BK_NEXT_PT;
        end else begin
          state_nxt = (p_seg == SEG_W'(1)) ? BK_DONE : BK_ACC_RD;
        end
      end
      BK_ACC_RD: state_nxt = BK_ACC;
      BK_ACC: begin
        acc_nxt = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
        k_nxt = k_r + SI_W'(1);
        if (SEG_W'(k_r) + SEG_W'(2) >= p_seg) begin
          state_nxt = BK_DONE;
        end else begin
          state_nxt = BK_ACC_RD;
        end
      end
      BK_DONE: begin
        if (which_r) begin
          vb_nxt = 1'b1;
          pos_b_nxt = sum_off[POS_W] ? POS_MAX : sum_off[POS_W-1:0];
        end else begin
          va_nxt = 1'b1;
          ra_nxt = p_rt;
          pos_a_nxt = sum_off[POS_W] ? POS_MAX : sum_off[POS_W-1:0];
        end
        state_nxt = BK_NEXT_PT;
      end
      BK_NEXT_PT: begin
        if (!which_r) begin
          which_nxt = 1'b1;
          state_nxt = BK_PT_RD;
        end else begin
          dist_nxt = '0;
          if (!va_r) begin
            st_nxt = ST_FIRST;
          end else if (!vb_r) begin
            st_nxt = ST_SECOND;
          end else if (ra_r != p_rt) begin
            st_nxt = ST_ROUTES;
          end else begin
            st_nxt = ST_OK;
            dist_nxt = (pos_a_r > pos_b_r) ? pos_a_r - pos_b_r : pos_b_r - pos_a_r;
          end
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_tready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r <= '0;
      rpres_r <= '0;
      ppres_r <= '0;
      for (int i = 0; i < ROUTES; i++) begin
        rtop_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      if (take && q_cmd.mode == MODE_SEG && seg_ok) begin
        rpres_r[q_cmd.route] <= 1'b1;
        if (q_cmd.segment > rtop_r[q_cmd.route]) begin
          rtop_r[q_cmd.route] <= q_cmd.segment;
        end
      end
      if (take && q_cmd.mode == MODE_POINT) begin
        ppres_r[q_cmd.point_id] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= q_cmd;
    end
    which_r <= which_nxt;
    k_r <= k_nxt;
    acc_r <= acc_nxt;
    pos_a_r <= pos_a_nxt;
    pos_b_r <= pos_b_nxt;
    va_r <= va_nxt;
    vb_r <= vb_nxt;
    ra_r <= ra_nxt;
    st_r <= st_nxt;
    dist_r <= dist_nxt;
  end

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    seg_rd_r <= seg_mem[seg_ra];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[q_cmd.point_id] <= {q_cmd.route, q_cmd.segment, q_cmd.point_offset};
    end
    pt_rd_r <= pt_mem[pt_ra];
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> state_r == BK_IDLE) else $error("took item while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(res_first))
    else $error("result dropped");
  a_ok_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_status != ST_OK |-> res_dist == '0) else $error("stray distance");
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_status == ST_FIRST |-> res_first == '0) else $error("bad first pos");
`endif

endmodule

FILE: hw/rtl/route_point_distance_table_core.sv
// route point distance table: keeps per-route segment lengths (16 routes x 64
// segments) and up to 256 norming points; mode 0 beats write a segment length,
// mode 1 beats store a point, mode 2 beats query the distance of two points and
// give one out beat, mode 3 beats are dropped. after reset a clearing pass
// zeroes all 1024 entries of the segment store; beats queue meanwhile but none
// are carried out. a front stage with a two-beat queue takes input beats while
// the back end works; a query runs to its out beat through one read of the
// segment length memory per segment step and a single accumulator loop, and the
// back end takes no new beat until that out beat is taken
module route_point_distance_table_core
  import rpdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[1:0] route[5:2] segment[12:6] seg_length[28:13] point_offset[44:29]
  // point_id[52:45] other_point_id[60:53], zero fill to 64
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0] first_position[23:2] second_position[45:24] distance[67:46],
  // zero fill to 72
  output logic [71:0] out_tdata
);

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [1:0] status;
  logic [POS_W-1:0] first_pos, second_pos, distance;

  // unpack the input beat
  assign in_cmd.mode = mode_t'(in_tdata[1:0]);
  assign in_cmd.route = in_tdata[5:2];
  assign in_cmd.segment = in_tdata[12:6];
  assign in_cmd.seg_length = in_tdata[28:13];
  assign in_cmd.point_offset = in_tdata[44:29];
  assign in_cmd.point_id = in_tdata[52:45];
  assign in_cmd.other_point_id = in_tdata[60:53];

  // front: accept and queue
  rpdt_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  // back: tables, query sequencer and result register
  rpdt_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .res_status(status), .res_first(first_pos),
    .res_second(second_pos), .res_dist(distance)
  );

  assign out_tdata = {4'd0, distance, second_pos, first_pos, status};

endmodule
